// ===== rtl/core/vsq_pkg.sv =====
// Package for the vertical surface query block.
// Holds table sizes, item kind codes, the stored entry layout and the
// controller-to-datapath command type. No dependencies.
package vsq_pkg;

   // Table geometry and field widths.
   localparam int ENTRIES   = 64;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = 7;
   localparam int COORD_W   = 24;
   localparam int SIZE_W    = 23;
   localparam int BOUND_W   = 26;
   localparam int SURF_W    = 25;
   localparam int WORLD_W   = 5;
   localparam int KIND_W    = 2;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 32;

   // Item kinds carried in tuser.
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GROUND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CEIL   = 2'd2;

   // Sentinels returned when no surface qualifies.
   localparam logic signed [BOUND_W-1:0] SURF_MIN = -26'sd16777216;
   localparam logic signed [BOUND_W-1:0] SURF_MAX = 26'sd16777215;

   // Tag that matches every world.
   localparam logic signed [WORLD_W-1:0] WORLD_ALL = -5'sd1;

   // One table entry: bounds at 9 fractional bits plus the world tag.
   typedef struct packed {
      logic signed [BOUND_W-1:0] x_lo;
      logic signed [BOUND_W-1:0] x_hi;
      logic signed [BOUND_W-1:0] y_lo;
      logic signed [BOUND_W-1:0] y_hi;
      logic signed [BOUND_W-1:0] z_lo;
      logic signed [BOUND_W-1:0] z_hi;
      logic signed [WORLD_W-1:0] tag;
   } plat_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             write_en;
      logic             start;
      logic             ground;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             out_zero;
      logic             finish;
   } vsq_cmd_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } vsq_state_type;

endpackage

// ===== rtl/core/vertical_surface_query.sv =====
// Top level of the vertical surface query block.
// Unpacks the stream payloads and joins vsq_ctrl and vsq_dpath.
// Depends on vsq_pkg, vsq_ctrl and vsq_dpath.
// Usage:
//   The req channel carries one transaction per item: tuser gives the kind
//   (load entry, ground query, ceiling query) and tdata the item fields.
//   The rsp channel returns exactly one transaction per request: tuser is
//   the found flag and tdata the surface height at 9 fractional bits.
//   The csr channel writes the number of table entries in use.
//   A load or an unused kind is answered with a zero result presented in the
//   cycle after acceptance; loads can follow back to back. A query scans the
//   first N entries of the table through one read port, one entry per cycle,
//   N being the entry count limited to 64; its result is registered once
//   the scan pipeline is empty, and no new request is taken until then.
//   A request waits until the block is idle and the result register is
//   empty or being drained.
//   Reset clears the control state and the entry count; table contents
//   are undefined until loaded.
//   When the receiver stalls, the result is held and no new request is
//   accepted until it is taken.
module vertical_surface_query
   import vsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata, lowest bit up: entry_index, point_x, point_y, point_z,
   // size_x, size_y, size_z, world
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: kind
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata, lowest bit up: surface_y, then zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: found
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_data
);

   vsq_cmd_type cmd;
   logic busy;
   logic rsp_found;
   logic signed [SURF_W-1:0] rsp_surface_y;

   // Controller.
   vsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .busy       (busy),
      .cmd        (cmd)
   );

   // Datapath, fed from the unpacked request fields.
   vsq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .entry_index   (req_tdata[5:0]),
      .point_x       ($signed(req_tdata[29:6])),
      .point_y       ($signed(req_tdata[53:30])),
      .point_z       ($signed(req_tdata[77:54])),
      .size_x        (req_tdata[100:78]),
      .size_y        (req_tdata[123:101]),
      .size_z        (req_tdata[146:124]),
      .world         ($signed(req_tdata[151:147])),
      .busy          (busy),
      .rsp_found     (rsp_found),
      .rsp_surface_y (rsp_surface_y)
   );

   // Response packing.
   assign rsp_tdata = {{(RSP_DATA_W - SURF_W){1'b0}}, rsp_surface_y};
   assign rsp_tuser = rsp_found;

endmodule

// ===== rtl/core/vsq_dpath.sv =====
// Datapath of the vertical surface query block: platform table memory,
// per-entry qualification pipeline, running best and result register.
// Depends on vsq_pkg.
module vsq_dpath
   import vsq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  vsq_cmd_type               cmd,
   input  logic [IDX_W-1:0]          entry_index,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [COORD_W-1:0] point_z,
   input  logic [SIZE_W-1:0]         size_x,
   input  logic [SIZE_W-1:0]         size_y,
   input  logic [SIZE_W-1:0]         size_z,
   input  logic signed [WORLD_W-1:0] world,
   output logic                      busy,
   output logic                      rsp_found,
   output logic signed [SURF_W-1:0]  rsp_surface_y
);

   plat_entry_type mem_ff [ENTRIES];
   plat_entry_type new_entry;
   plat_entry_type rd_data_ff;
   logic rd_valid_ff;
   logic hit_valid_ff;
   logic hit_ff, hit_in;
   logic signed [BOUND_W-1:0] h_ff, h_in;
   logic signed [BOUND_W-1:0] qx_ff, qz_ff, lim_ff;
   logic signed [WORLD_W-1:0] qworld_ff;
   logic ground_ff;
   logic signed [BOUND_W-1:0] best_ff;
   logic found_ff;
   logic better;
   logic signed [BOUND_W-1:0] cx2, cy2, cz2, sx, sy, sz;
   logic out_found_ff;
   logic signed [SURF_W-1:0] out_surf_ff;

   // Doubled centres and zero-extended extents at 9 fractional bits.
   assign cx2 = $signed({point_x[COORD_W-1], point_x, 1'b0});
   assign cy2 = $signed({point_y[COORD_W-1], point_y, 1'b0});
   assign cz2 = $signed({point_z[COORD_W-1], point_z, 1'b0});
   assign sx  = $signed({3'b000, size_x});
   assign sy  = $signed({3'b000, size_y});
   assign sz  = $signed({3'b000, size_z});

   // Bounds of an entry being loaded.
   always_comb begin
      new_entry.x_lo = cx2 - sx;
      new_entry.x_hi = cx2 + sx;
      new_entry.y_lo = cy2 - sy;
      new_entry.y_hi = cy2 + sy;
      new_entry.z_lo = cz2 - sz;
      new_entry.z_hi = cz2 + sz;
      new_entry.tag  = world;
   end

   // Table memory: one write port for loads, one registered read port for scans.
   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem_ff[entry_index] <= new_entry;
      end
      rd_data_ff <= mem_ff[cmd.rd_addr];
   end

   // Query operands latched when a query transaction is accepted.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qx_ff     <= cx2;
         qz_ff     <= cz2;
         lim_ff    <= cy2;
         qworld_ff <= world;
         ground_ff <= cmd.ground;
      end
   end

   // Qualify the entry just read: tag, footprint and height limit.
   always_comb begin
      logic tag_ok;
      logic foot_ok;
      tag_ok  = (rd_data_ff.tag == WORLD_ALL) || (rd_data_ff.tag == qworld_ff);
      foot_ok = (qx_ff >= rd_data_ff.x_lo) && (qx_ff <= rd_data_ff.x_hi) &&
                (qz_ff >= rd_data_ff.z_lo) && (qz_ff <= rd_data_ff.z_hi);
      if (ground_ff) begin
         h_in   = rd_data_ff.y_hi;
         hit_in = tag_ok && foot_ok && (rd_data_ff.y_hi <= lim_ff);
      end else begin
         h_in   = rd_data_ff.y_lo;
         hit_in = tag_ok && foot_ok && (rd_data_ff.y_lo >= lim_ff);
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         hit_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.rd_en;
         hit_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      h_ff   <= h_in;
   end

   assign busy = rd_valid_ff | hit_valid_ff;

   // A candidate replaces the best when it is the first hit or strictly better.
   assign better = !found_ff || (ground_ff ? (h_ff > best_ff) : (h_ff < best_ff));

   // Running best over the scan.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_ff  <= cmd.ground ? SURF_MIN : SURF_MAX;
         found_ff <= 1'b0;
      end else if (hit_valid_ff && hit_ff && better) begin
         best_ff  <= h_ff;
         found_ff <= 1'b1;
      end
   end

   // Result register toward the response channel.
   always_ff @(posedge clock) begin
      if (cmd.out_zero) begin
         out_found_ff <= 1'b0;
         out_surf_ff  <= '0;
      end else if (cmd.finish) begin
         out_found_ff <= found_ff;
         out_surf_ff  <= best_ff[SURF_W-1:0];
      end
   end

   assign rsp_found     = out_found_ff;
   assign rsp_surface_y = out_surf_ff;

endmodule

// ===== rtl/core/vsq_ctrl.sv =====
// Controller of the vertical surface query block: handshakes, entry count
// register, scan address sequencing and result valid.
// Depends on vsq_pkg.
module vsq_ctrl
   import vsq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [KIND_W-1:0] req_kind,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_data,
   input  logic              busy,
   output vsq_cmd_type       cmd
);

   vsq_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0] eff_count;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic is_query;

   // Entry count register; the user is to write it only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // A count above the table size scans the whole table.
   assign eff_count = (count_ff > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : count_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_query   = (req_kind == KIND_GROUND) || (req_kind == KIND_CEIL);

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cmd          = '0;
      cmd.ground   = (req_kind == KIND_GROUND);
      cmd.rd_addr  = addr_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.write_en = (req_kind == KIND_LOAD);
               if (is_query) begin
                  cmd.start = 1'b1;
                  addr_in   = '0;
                  state_in  = (eff_count == '0) ? ST_DRAIN : ST_SCAN;
               end else begin
                  cmd.out_zero = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (CNT_W'(addr_ff + 1'b1) == eff_count) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy && out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // Result valid: set when a result is loaded, cleared when it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_zero || cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // The scan address stays inside the entries in use.
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff < eff_count))
      else $error("scan address beyond entry count");

   // A query over a non-empty table starts a scan.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (accept && is_query && (eff_count != '0)) |=> (state_ff == ST_SCAN))
      else $error("query did not start a scan");

   // A finished query presents its result on the next cycle.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished query left no result");

   // The datapath pipeline is empty whenever the controller is idle.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy)
      else $error("datapath busy while idle");

endmodule

// ===== tb/tb_vertical_surface_query.sv =====
// Self-checking testbench for the vertical surface query block.
// Drives load, ground, ceiling and unused-kind transactions, predicts every response
// from its own platform table, and depends only on vsq_pkg and vertical_surface_query.
module tb_vertical_surface_query
   import vsq_pkg::*;
();

   // Kind code that the block accepts but does not act on.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One request transaction as separate fields.
   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic [IDX_W-1:0]          slot;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic [SIZE_W-1:0]         sx;
      logic [SIZE_W-1:0]         sy;
      logic [SIZE_W-1:0]         sz;
      logic signed [WORLD_W-1:0] world;
   } surface_item_type;

   // One response transaction as separate fields.
   typedef struct {
      logic              found;
      logic [SURF_W-1:0] surface;
   } surface_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data = '0;

   // Shadow copy of the block's table and entry count.
   plat_entry_type     platform_table [ENTRIES];
   logic [CNT_W-1:0]   platform_count_model = '0;
   surface_result_type expected_surfaces [$];

   bit                req_quiet = 1'b0;
   bit                rsp_quiet = 1'b0;
   int unsigned       rsp_hold = 0;
   int                error_count = 0;
   int                results_seen = 0;
   int                hits_seen = 0;
   int                loads_sent = 0;
   int                ground_sent = 0;
   int                ceiling_sent = 0;
   int                unused_sent = 0;
   int                count_writes = 0;

   vertical_surface_query i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Doubles a centre to 9 fractional bits.
   function automatic logic signed [BOUND_W-1:0] to_half_units(input logic signed [COORD_W-1:0] v);
      return {v[COORD_W-1], v, 1'b0};
   endfunction

   // Updates the shadow table for a load and returns the response the block must give.
   function automatic surface_result_type predict_surface(input surface_item_type it);
      surface_result_type        r;
      logic signed [BOUND_W-1:0] px;
      logic signed [BOUND_W-1:0] pz;
      logic signed [BOUND_W-1:0] lim;
      logic signed [BOUND_W-1:0] h;
      logic signed [BOUND_W-1:0] best;
      bit                      hit;
      bit                      ground;
      int                      n;
      r.found   = 1'b0;
      r.surface = '0;
      case (it.kind)
         KIND_LOAD: begin
            platform_table[it.slot].x_lo = to_half_units(it.px) - $signed({3'b000, it.sx});
            platform_table[it.slot].x_hi = to_half_units(it.px) + $signed({3'b000, it.sx});
            platform_table[it.slot].y_lo = to_half_units(it.py) - $signed({3'b000, it.sy});
            platform_table[it.slot].y_hi = to_half_units(it.py) + $signed({3'b000, it.sy});
            platform_table[it.slot].z_lo = to_half_units(it.pz) - $signed({3'b000, it.sz});
            platform_table[it.slot].z_hi = to_half_units(it.pz) + $signed({3'b000, it.sz});
            platform_table[it.slot].tag  = it.world;
         end
         KIND_GROUND, KIND_CEIL: begin
            ground = (it.kind == KIND_GROUND);
            px     = to_half_units(it.px);
            pz     = to_half_units(it.pz);
            lim    = to_half_units(it.py);
            best   = ground ? SURF_MIN : SURF_MAX;
            hit    = 1'b0;
            n      = (platform_count_model > ENTRIES) ? ENTRIES : int'(platform_count_model);
            for (int i = 0; i < n; i++) begin
               if (platform_table[i].tag != WORLD_ALL && platform_table[i].tag != it.world)
                  continue;
               if (px < platform_table[i].x_lo || px > platform_table[i].x_hi ||
                   pz < platform_table[i].z_lo || pz > platform_table[i].z_hi)
                  continue;
               if (ground) begin
                  h = platform_table[i].y_hi;
                  if (h <= lim && (!hit || h > best)) begin
                     best = h;
                     hit  = 1'b1;
                  end
               end else begin
                  h = platform_table[i].y_lo;
                  if (h >= lim && (!hit || h < best)) begin
                     best = h;
                     hit  = 1'b1;
                  end
               end
            end
            r.found   = hit;
            r.surface = best[SURF_W-1:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic surface_item_type make_box(
      input logic [IDX_W-1:0] slot,
      input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
      input logic signed [COORD_W-1:0] cz,
      input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz,
      input logic signed [WORLD_W-1:0] world);
      surface_item_type it;
      it.kind  = KIND_LOAD;
      it.slot  = slot;
      it.px    = cx;
      it.py    = cy;
      it.pz    = cz;
      it.sx    = sx;
      it.sy    = sy;
      it.sz    = sz;
      it.world = world;
      return it;
   endfunction

   function automatic surface_item_type make_query(
      input logic [KIND_W-1:0] kind,
      input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] limit_y,
      input logic signed [COORD_W-1:0] z, input logic signed [WORLD_W-1:0] world);
      surface_item_type it;
      it       = make_box('0, x, limit_y, z, '0, '0, '0, world);
      it.kind  = kind;
      return it;
   endfunction

   // Coordinates mostly fall in a small cluster so that queries hit several boxes.
   function automatic logic [COORD_W-1:0] pick_coord(input bit wide);
      if (wide)
         return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(0, 4095)) - 2048);
   endfunction

   function automatic logic signed [WORLD_W-1:0] pick_world(input bit is_load);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (is_load && roll < 3)
         return WORLD_ALL;
      if (!is_load && roll == 0)
         return WORLD_ALL;
      if (roll == 9)
         return WORLD_W'($urandom_range(0, 15));
      return WORLD_W'($urandom_range(0, 3));
   endfunction

   function automatic surface_item_type make_random_item();
      surface_item_type it;
      int unsigned   roll;
      bit            wide;
      roll     = $urandom_range(0, 99);
      wide     = ($urandom_range(0, 4) == 0);
      it.slot  = IDX_W'($urandom_range(0, ENTRIES - 1));
      it.px    = pick_coord(wide);
      it.py    = pick_coord(wide);
      it.pz    = pick_coord(wide);
      it.sx    = SIZE_W'($urandom);
      it.sy    = SIZE_W'($urandom);
      it.sz    = SIZE_W'($urandom);
      if (roll < 25) begin
         it.kind  = KIND_LOAD;
         it.world = pick_world(1'b1);
         if (!wide) begin
            it.sx = SIZE_W'($urandom_range(0, 6000));
            it.sy = SIZE_W'($urandom_range(0, 6000));
            it.sz = SIZE_W'($urandom_range(0, 6000));
         end
      end else if (roll < 95) begin
         it.kind  = (roll < 60) ? KIND_GROUND : KIND_CEIL;
         it.world = pick_world(1'b0);
      end else begin
         it.kind  = KIND_UNUSED;
         it.world = WORLD_W'($urandom);
      end
      return it;
   endfunction

   // Sends one request transaction after a random gap and records its prediction.
   task automatic send_item(input surface_item_type it);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_surfaces.push_back(predict_surface(it));
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {it.world, it.sz, it.sy, it.sx, it.pz, it.py, it.px, it.slot};
      do @(posedge clock); while (!req_tready);
      case (it.kind)
         KIND_LOAD:   loads_sent++;
         KIND_GROUND: ground_sent++;
         KIND_CEIL:   ceiling_sent++;
         default:     unused_sent++;
      endcase
   endtask

   // Stops sending and waits until every predicted response has been taken.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_surfaces.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_platform_count(input logic [CNT_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      platform_count_model = value;
      count_writes++;
      @(posedge clock);
   endtask

   // Empty table: both sentinels and a load into the last slot.
   task automatic test_empty_table();
      write_platform_count(0);
      send_item(make_query(KIND_GROUND, 0, 0, 0, 0));
      send_item(make_query(KIND_CEIL, 0, 0, 0, 0));
      send_item(make_box(IDX_W'(ENTRIES - 1), -1, -1, -1, '1, '1, '1, -1));
   endtask

   // Hand-built boxes: edges, ties, world tags and extreme coordinates.
   task automatic test_directed_surfaces();
      surface_item_type it;
      it      = make_query(KIND_UNUSED, -1, -1, -1, -1);
      it.slot = '1;
      it.sx   = '1;
      it.sy   = '1;
      it.sz   = '1;
      send_item(it);
      send_item(make_box(0, 0, 0, 0, 512, 512, 512, WORLD_ALL));
      send_item(make_box(1, 0, 256, 0, 512, 512, 512, 2));
      send_item(make_box(2, 0, 256, 0, 512, 512, 512, WORLD_ALL));
      send_item(make_box(3, 8388607, -8388608, -8388608, 8388607, 8388607, 8388607, 15));
      send_item(make_box(4, -8388608, 8388607, 8388607, 0, 0, 0, 0));
      send_item(make_box(5, 0, 4096, 0, 512, 512, 512, 7));
      write_platform_count(6);
      send_item(make_query(KIND_GROUND, 0, 256, 0, 2));
      // Two equal tops: the first hit stands.
      send_item(make_query(KIND_GROUND, 0, 1000, 0, 2));
      // Footprint edges are inclusive; one step past the edge misses.
      send_item(make_query(KIND_GROUND, 256, 8388607, -256, 7));
      send_item(make_query(KIND_GROUND, 257, 8388607, 0, 7));
      send_item(make_query(KIND_CEIL, 0, -256, 0, 2));
      send_item(make_query(KIND_CEIL, 0, -256, 0, 5));
      send_item(make_query(KIND_CEIL, 0, 1000, 0, 7));
      send_item(make_query(KIND_CEIL, 0, 1000, 0, 8));
      send_item(make_query(KIND_GROUND, -8388608, 8388607, 8388607, 0));
      send_item(make_query(KIND_CEIL, -8388608, -8388608, 8388607, 0));
      send_item(make_query(KIND_GROUND, 8388607, 8388607, -8388608, 15));
      send_item(make_query(KIND_CEIL, 8388607, -8388608, -8388608, 15));
      send_item(make_query(KIND_CEIL, 8388607, -8388608, -8388608, 3));
   endtask

   // Writes every slot so that any entry count reads only loaded entries.
   task automatic test_fill_table();
      surface_item_type it;
      for (int i = 0; i < ENTRIES; i++) begin
         it      = make_random_item();
         it.kind = KIND_LOAD;
         it.slot = IDX_W'(i);
         it.sx   = SIZE_W'($urandom_range(0, 6000));
         it.sy   = SIZE_W'($urandom_range(0, 6000));
         it.sz   = SIZE_W'($urandom_range(0, 6000));
         it.world = pick_world(1'b1);
         send_item(it);
      end
   endtask

   // Full table, counts beyond the table, and a single entry.
   task automatic test_count_extremes();
      logic [CNT_W-1:0] counts [4];
      surface_item_type it;
      counts = '{CNT_W'(ENTRIES), {CNT_W{1'b1}}, CNT_W'(ENTRIES + 1), CNT_W'(1)};
      foreach (counts[c]) begin
         write_platform_count(counts[c]);
         repeat (4) begin
            it      = make_random_item();
            it.kind = ($urandom_range(0, 1) == 0) ? KIND_GROUND : KIND_CEIL;
            send_item(it);
         end
      end
   endtask

   // Random traffic in phases, each with its own entry count and idling pattern.
   task automatic test_random_traffic();
      logic [CNT_W-1:0] counts [8];
      counts = '{CNT_W'(ENTRIES), CNT_W'(1), {CNT_W{1'b1}}, CNT_W'(0), CNT_W'(33),
                 CNT_W'(ENTRIES + 1), CNT_W'(2), CNT_W'(ENTRIES)};
      for (int phase = 0; phase < 12; phase++) begin
         write_platform_count((phase < 8) ? counts[phase] : CNT_W'($urandom_range(0, 127)));
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(0, 59) == 0)
               drain_pipeline();
            send_item(make_random_item());
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // Response side: stalls after some transactions and at random otherwise.
   always @(posedge clock) begin
      int unsigned pause;
      pause = rsp_quiet ? 0 : $urandom_range(0, 8);
      if (rsp_tvalid && rsp_tready) begin
         rsp_hold   <= pause;
         rsp_tready <= (pause == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (!rsp_quiet && $urandom_range(0, 15) == 0) begin
         rsp_hold   <= pause;
         rsp_tready <= (pause == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each response transaction with the oldest prediction.
   always @(posedge clock) begin
      surface_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_surfaces.size() == 0) begin
            $error("unexpected response: found %0d, surface_y %0d",
                   rsp_tuser, $signed(rsp_tdata[SURF_W-1:0]));
            error_count++;
         end else begin
            want = expected_surfaces.pop_front();
            results_seen++;
            if (want.found)
               hits_seen++;
            if (rsp_tuser !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[SURF_W-1:0] !== want.surface) begin
               $error("surface_y: expected %0d, actual %0d",
                      $signed(want.surface), $signed(rsp_tdata[SURF_W-1:0]));
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:SURF_W] !== '0) begin
               $error("tdata fill: expected 0, actual %0h", rsp_tdata[RSP_DATA_W-1:SURF_W]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed_surfaces();
      test_fill_table();
      test_count_extremes();
      test_random_traffic();
      drain_pipeline();
      repeat (80) @(posedge clock);
      $display("Sent %0d loads, %0d ground and %0d ceiling queries, %0d unused kinds.",
               loads_sent, ground_sent, ceiling_sent, unused_sent);
      $display("Checked %0d responses, %0d with a surface found, over %0d entry count settings.",
               results_seen, hits_seen, count_writes);
      if (error_count == 0)
         $display("[vertical_surface_query] OK");
      else
         $display("[vertical_surface_query] ERROR");
      $finish;
   end

   // Hard limit on the run in case the block stops answering.
   initial begin
      #4000000;
      $display("[vertical_surface_query] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/vsq_pkg.sv
rtl/core/vsq_dpath.sv
rtl/core/vsq_ctrl.sv
rtl/core/vertical_surface_query.sv
tb/tb_vertical_surface_query.sv
